// File: sv/vca_pkg.sv
// ----------------------------------------------------------------------------
// vca_pkg
// Shared types and constants for the visibility channel average unit.
// ----------------------------------------------------------------------------
package vca_pkg;

   localparam int MAX_CHANNELS = 16384;
   localparam int SAMPLE_W     = 16;
   localparam int REG_W        = 15;
   localparam int CHAN_W       = 15;
   localparam int OUT_CHAN_W   = 14;
   localparam int ACC_W        = 31;
   localparam int IDX_W        = 2;
   localparam int DIV_STEPS    = ACC_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int FIFO_DEPTH   = 2;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

   localparam logic [IDX_W-1:0] REG_START = 2'd0;
   localparam logic [IDX_W-1:0] REG_END   = 2'd1;
   localparam logic [IDX_W-1:0] REG_WIDTH = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_re;
      logic signed [SAMPLE_W-1:0] sample_im;
      logic                       sample_flag;
      logic [CHAN_W-1:0]          chan_num;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] avg_re;
      logic signed [SAMPLE_W-1:0] avg_im;
      logic                       avg_flag;
      logic [OUT_CHAN_W-1:0]      out_chan;
      logic                       last_out;
   } rsp_type;

   // one finished group: exact sums waiting for the divide
   typedef struct packed {
      logic signed [ACC_W-1:0] sum_re;
      logic signed [ACC_W-1:0] sum_im;
      logic                    flag;
      logic [OUT_CHAN_W-1:0]   out_chan;
      logic                    last;
   } grp_type;

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_DIV  = 3'b010,
      BK_WAIT = 3'b100
   } back_state_type;

endpackage

// File: sv/vca_div.sv
// ----------------------------------------------------------------------------
// vca_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vca_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [vca_pkg::ACC_W-1:0]   dividend,
   input  logic [vca_pkg::REG_W-1:0]   divisor,
   output logic                        done,
   output logic [vca_pkg::ACC_W-1:0]   quotient,
   output logic [vca_pkg::REG_W-1:0]   remainder
);

   logic [vca_pkg::ACC_W-1:0]     quo_ff, quo_in;
   logic [vca_pkg::REG_W-1:0]     rem_ff, rem_in;
   logic [vca_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [vca_pkg::REG_W:0]       trial;
   logic [vca_pkg::REG_W:0]       diff;
   logic                          fits;

   assign trial = {rem_ff, quo_ff[vca_pkg::ACC_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[vca_pkg::ACC_W-2:0], fits};
         rem_in = fits ? diff[vca_pkg::REG_W-1:0] : trial[vca_pkg::REG_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == vca_pkg::DIV_CNT_W'(vca_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// File: sv/vca_fifo.sv
// ----------------------------------------------------------------------------
// vca_fifo
// Short queue of finished groups between the front and back parts.
// ----------------------------------------------------------------------------
module vca_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vca_pkg::grp_type  push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output vca_pkg::grp_type  rd_data
);

   vca_pkg::grp_type            mem_ff [vca_pkg::FIFO_DEPTH];
   logic [vca_pkg::FIFO_AW-1:0] wr_ff, wr_in;
   logic [vca_pkg::FIFO_AW-1:0] rd_ff, rd_in;
   logic [vca_pkg::FIFO_AW:0]   cnt_ff, cnt_in;
   logic                        do_push;
   logic                        do_pop;

   assign full    = (cnt_ff == (vca_pkg::FIFO_AW + 1)'(vca_pkg::FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: sv/vca_front.sv
// ----------------------------------------------------------------------------
// vca_front
// Configuration registers and check, channel selection and group sums.
// ----------------------------------------------------------------------------
module vca_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [vca_pkg::IDX_W-1:0]   csr_index,
   input  logic [vca_pkg::REG_W-1:0]   csr_wdata,
   input  logic                        req_push,
   output logic                        req_full,
   input  vca_pkg::req_type            req_data,
   input  logic                        grp_full,
   output logic                        grp_push,
   output vca_pkg::grp_type            grp_data,
   output logic [vca_pkg::REG_W-1:0]   avg_width
);

   logic [vca_pkg::REG_W-1:0]      start_ff, start_in;
   logic [vca_pkg::REG_W-1:0]      end_ff, end_in;
   logic [vca_pkg::REG_W-1:0]      width_ff, width_in;
   logic                           cfg_ok_ff, cfg_ok_in;
   logic [vca_pkg::REG_W-1:0]      nout_ff, nout_in;
   logic                           chk_pend_ff, chk_pend_in;
   logic                           chk_busy_ff, chk_busy_in;
   logic signed [vca_pkg::ACC_W-1:0] acc_re_ff, acc_re_in;
   logic signed [vca_pkg::ACC_W-1:0] acc_im_ff, acc_im_in;
   logic                           acc_flag_ff, acc_flag_in;
   logic [vca_pkg::REG_W-1:0]      gcount_ff, gcount_in;
   logic [vca_pkg::OUT_CHAN_W-1:0] oidx_ff, oidx_in;

   logic                           basic_ok;
   logic [vca_pkg::REG_W-1:0]      span;
   logic                           chk_start;
   logic                           chk_done;
   logic [vca_pkg::ACC_W-1:0]      chk_quo;
   logic [vca_pkg::REG_W-1:0]      chk_rem;
   logic                           accept;
   logic                           keep;
   logic signed [vca_pkg::ACC_W-1:0] sum_re;
   logic signed [vca_pkg::ACC_W-1:0] sum_im;
   logic                           sum_flag;
   logic [vca_pkg::REG_W-1:0]      gcount_nx;
   logic                           grp_end;
   logic [vca_pkg::REG_W-1:0]      oidx_nx;
   logic                           is_last;

   assign basic_ok = (start_ff != '0) && (width_ff != '0) && (end_ff >= start_ff)
                     && (end_ff <= vca_pkg::REG_W'(vca_pkg::MAX_CHANNELS));
   assign span      = end_ff - start_ff + 1'b1;
   assign chk_start = chk_pend_ff && !csr_we && basic_ok;

   vca_div u_chk_div (
      .clock     (clock),
      .reset     (reset),
      .start     (chk_start),
      .dividend  (vca_pkg::ACC_W'(span)),
      .divisor   (width_ff),
      .done      (chk_done),
      .quotient  (chk_quo),
      .remainder (chk_rem)
   );

   assign req_full = chk_pend_ff || chk_busy_ff || grp_full;
   assign accept   = req_push && !req_full;
   assign keep     = cfg_ok_ff && (req_data.chan_num >= start_ff)
                     && (req_data.chan_num <= end_ff);

   assign sum_re    = acc_re_ff + {{(vca_pkg::ACC_W - vca_pkg::SAMPLE_W)
                                    {req_data.sample_re[vca_pkg::SAMPLE_W-1]}},
                                   req_data.sample_re};
   assign sum_im    = acc_im_ff + {{(vca_pkg::ACC_W - vca_pkg::SAMPLE_W)
                                    {req_data.sample_im[vca_pkg::SAMPLE_W-1]}},
                                   req_data.sample_im};
   assign sum_flag  = acc_flag_ff | req_data.sample_flag;
   assign gcount_nx = gcount_ff + 1'b1;
   assign grp_end   = (gcount_nx == width_ff);
   assign oidx_nx   = {1'b0, oidx_ff} + 1'b1;
   assign is_last   = (oidx_nx >= nout_ff);

   assign grp_push          = accept && keep && grp_end;
   assign grp_data.sum_re   = sum_re;
   assign grp_data.sum_im   = sum_im;
   assign grp_data.flag     = sum_flag;
   assign grp_data.out_chan = oidx_ff;
   assign grp_data.last     = is_last;
   assign avg_width         = width_ff;

   always_comb begin
      start_in    = start_ff;
      end_in      = end_ff;
      width_in    = width_ff;
      cfg_ok_in   = cfg_ok_ff;
      nout_in     = nout_ff;
      chk_pend_in = chk_pend_ff;
      chk_busy_in = chk_busy_ff;
      acc_re_in   = acc_re_ff;
      acc_im_in   = acc_im_ff;
      acc_flag_in = acc_flag_ff;
      gcount_in   = gcount_ff;
      oidx_in     = oidx_ff;

      if (accept && keep) begin
         if (grp_end) begin
            acc_re_in   = '0;
            acc_im_in   = '0;
            acc_flag_in = 1'b0;
            gcount_in   = '0;
            oidx_in     = is_last ? '0 : oidx_nx[vca_pkg::OUT_CHAN_W-1:0];
         end else begin
            acc_re_in   = sum_re;
            acc_im_in   = sum_im;
            acc_flag_in = sum_flag;
            gcount_in   = gcount_nx;
         end
      end

      if (csr_we) begin
         case (csr_index)
            vca_pkg::REG_START: begin
               start_in = csr_wdata;
            end
            vca_pkg::REG_END: begin
               end_in = csr_wdata;
            end
            vca_pkg::REG_WIDTH: begin
               width_in = csr_wdata;
            end
            default: begin
            end
         endcase
         if (csr_index == vca_pkg::REG_START || csr_index == vca_pkg::REG_END
             || csr_index == vca_pkg::REG_WIDTH) begin
            cfg_ok_in   = 1'b0;
            chk_pend_in = 1'b1;
            chk_busy_in = 1'b0;
            acc_re_in   = '0;
            acc_im_in   = '0;
            acc_flag_in = 1'b0;
            gcount_in   = '0;
            oidx_in     = '0;
         end
      end else if (chk_pend_ff) begin
         chk_pend_in = 1'b0;
         chk_busy_in = basic_ok;
      end else if (chk_busy_ff && chk_done) begin
         chk_busy_in = 1'b0;
         cfg_ok_in   = (chk_rem == '0);
         nout_in     = chk_quo[vca_pkg::REG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff    <= vca_pkg::REG_W'(1);
         end_ff      <= vca_pkg::REG_W'(vca_pkg::MAX_CHANNELS);
         width_ff    <= vca_pkg::REG_W'(1);
         cfg_ok_ff   <= 1'b1;
         nout_ff     <= vca_pkg::REG_W'(vca_pkg::MAX_CHANNELS);
         chk_pend_ff <= 1'b0;
         chk_busy_ff <= 1'b0;
         acc_re_ff   <= '0;
         acc_im_ff   <= '0;
         acc_flag_ff <= 1'b0;
         gcount_ff   <= '0;
         oidx_ff     <= '0;
      end else begin
         start_ff    <= start_in;
         end_ff      <= end_in;
         width_ff    <= width_in;
         cfg_ok_ff   <= cfg_ok_in;
         nout_ff     <= nout_in;
         chk_pend_ff <= chk_pend_in;
         chk_busy_ff <= chk_busy_in;
         acc_re_ff   <= acc_re_in;
         acc_im_ff   <= acc_im_in;
         acc_flag_ff <= acc_flag_in;
         gcount_ff   <= gcount_in;
         oidx_ff     <= oidx_in;
      end
   end

endmodule

// File: sv/vca_back.sv
// ----------------------------------------------------------------------------
// vca_back
// Divides each finished group by the width and holds the result beat.
// ----------------------------------------------------------------------------
module vca_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        grp_empty,
   output logic                        grp_pop,
   input  vca_pkg::grp_type            grp_data,
   input  logic [vca_pkg::REG_W-1:0]   avg_width,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output vca_pkg::rsp_type            rsp_data
);

   vca_pkg::back_state_type        state_ff, state_in;
   logic                           neg_re_ff, neg_re_in;
   logic                           neg_im_ff, neg_im_in;
   logic                           flag_ff, flag_in;
   logic [vca_pkg::OUT_CHAN_W-1:0] chan_ff, chan_in;
   logic                           last_ff, last_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   vca_pkg::rsp_type               rsp_ff, rsp_in;

   logic                           div_start;
   logic [vca_pkg::ACC_W-1:0]      mag_re;
   logic [vca_pkg::ACC_W-1:0]      mag_im;
   logic                           done_re;
   logic                           done_im;
   logic [vca_pkg::ACC_W-1:0]      quo_re;
   logic [vca_pkg::ACC_W-1:0]      quo_im;
   logic [vca_pkg::REG_W-1:0]      rem_re;
   logic [vca_pkg::REG_W-1:0]      rem_im;
   logic [vca_pkg::SAMPLE_W-1:0]   res_re;
   logic [vca_pkg::SAMPLE_W-1:0]   res_im;
   logic                           out_free;

   assign div_start = (state_ff == vca_pkg::BK_IDLE) && !grp_empty;
   assign grp_pop   = div_start;
   assign mag_re    = grp_data.sum_re[vca_pkg::ACC_W-1] ? -grp_data.sum_re : grp_data.sum_re;
   assign mag_im    = grp_data.sum_im[vca_pkg::ACC_W-1] ? -grp_data.sum_im : grp_data.sum_im;

   vca_div u_div_re (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_re),
      .divisor   (avg_width),
      .done      (done_re),
      .quotient  (quo_re),
      .remainder (rem_re)
   );

   vca_div u_div_im (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (mag_im),
      .divisor   (avg_width),
      .done      (done_im),
      .quotient  (quo_im),
      .remainder (rem_im)
   );

   // truncation toward zero: divide magnitudes, then restore the sign
   assign res_re   = neg_re_ff ? -quo_re[vca_pkg::SAMPLE_W-1:0] : quo_re[vca_pkg::SAMPLE_W-1:0];
   assign res_im   = neg_im_ff ? -quo_im[vca_pkg::SAMPLE_W-1:0] : quo_im[vca_pkg::SAMPLE_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_pop;

   always_comb begin
      state_in     = state_ff;
      neg_re_in    = neg_re_ff;
      neg_im_in    = neg_im_ff;
      flag_in      = flag_ff;
      chan_in      = chan_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;
      case (state_ff)
         vca_pkg::BK_IDLE: begin
            if (div_start) begin
               neg_re_in = grp_data.sum_re[vca_pkg::ACC_W-1];
               neg_im_in = grp_data.sum_im[vca_pkg::ACC_W-1];
               flag_in   = grp_data.flag;
               chan_in   = grp_data.out_chan;
               last_in   = grp_data.last;
               state_in  = vca_pkg::BK_DIV;
            end
         end
         vca_pkg::BK_DIV: begin
            if (done_re && done_im && (rem_re == rem_re) && (rem_im == rem_im)) begin
               state_in = vca_pkg::BK_WAIT;
            end
         end
         vca_pkg::BK_WAIT: begin
            if (out_free) begin
               rsp_in.avg_re   = res_re;
               rsp_in.avg_im   = res_im;
               rsp_in.avg_flag = flag_ff;
               rsp_in.out_chan = chan_ff;
               rsp_in.last_out = last_ff;
               rsp_valid_in    = 1'b1;
               state_in        = vca_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = vca_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= vca_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_re_ff <= neg_re_in;
      neg_im_ff <= neg_im_in;
      flag_ff   <= flag_in;
      chan_ff   <= chan_in;
      last_ff   <= last_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/visibility_channel_average_unit.sv
// ----------------------------------------------------------------------------
// visibility_channel_average_unit
// Channel selection and boxcar averaging of one spectrum of visibilities.
//
//   port group   dir   handshake            beat
//   req_         in    req_push / req_full  one sample with flag and channel
//   rsp_         out   rsp_empty / rsp_pop  one averaged output channel
//   csr_         in    csr_we               register index and value
//
// a sample beat is taken every cycle while the group queue has room and no check runs
// each finished group is divided by the width in the shared-width divider pair,
// and the back part takes the next group only after the last result is registered
// after a register write, req_full stays high while the configuration check runs
// reset (synchronous) loads start 1, end 16384, width 1 and clears all sums
// ----------------------------------------------------------------------------
module visibility_channel_average_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [vca_pkg::IDX_W-1:0]   csr_index,
   input  logic [vca_pkg::REG_W-1:0]   csr_wdata,
   input  logic                        req_push,
   output logic                        req_full,
   input  vca_pkg::req_type            req_data,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output vca_pkg::rsp_type            rsp_data
);

   logic                       grp_push;
   logic                       grp_full;
   logic                       grp_empty;
   logic                       grp_pop;
   vca_pkg::grp_type           grp_wr;
   vca_pkg::grp_type           grp_rd;
   logic [vca_pkg::REG_W-1:0]  avg_width;

   vca_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .grp_full  (grp_full),
      .grp_push  (grp_push),
      .grp_data  (grp_wr),
      .avg_width (avg_width)
   );

   vca_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (grp_push),
      .push_data (grp_wr),
      .pop       (grp_pop),
      .full      (grp_full),
      .empty     (grp_empty),
      .rd_data   (grp_rd)
   );

   vca_back u_back (
      .clock     (clock),
      .reset     (reset),
      .grp_empty (grp_empty),
      .grp_pop   (grp_pop),
      .grp_data  (grp_rd),
      .avg_width (avg_width),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
